// ----- rtl/gbc_pkg.sv -----
// Shared types and fixed widths for the gyroscope bias calibrator.
// No dependencies; imported by gyro_bias_calibrator.
`timescale 1ns / 1ps

package gbc_pkg;

  localparam int NUM_AXES = 3;
  localparam int SAMPLE_W = 16;
  localparam int CORR_W   = 17;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [CORR_W-1:0]   corr_t;
  typedef logic        [SAMPLE_W-1:0] quot_t;

  typedef sample_t sample_vec_t [NUM_AXES];
  typedef corr_t   corr_vec_t   [NUM_AXES];

endpackage

// ----- rtl/gyro_bias_calibrator.sv -----
// Gyroscope zero-rate bias calibrator: warmup, per-axis averaging, bias removal.
// Depends on gbc_pkg (sample and result types).
`timescale 1ns / 1ps

//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid, in_ready  | restart, rate_x, rate_y, rate_z
//  out     | out_valid, out_ready| corrected_x/y/z, calibrated
//
// Four register stages: accumulate, magnitude, reciprocal multiply, bias and
// subtract. One request per cycle enters while out_ready does not stall the pipe.
// The average uses a constant reciprocal multiply, one stage of the pipe.
// Reset clears the counter, done flag, sums, bias and all stage valids.
// Bubbles collapse: a request is taken while a result waits if a stage is empty.

module gyro_bias_calibrator #(
  parameter int WARMUP_SAMPLES  = 800,
  parameter int AVERAGE_SAMPLES = 800
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              restart,
  input  gbc_pkg::sample_t  rate_x,
  input  gbc_pkg::sample_t  rate_y,
  input  gbc_pkg::sample_t  rate_z,
  output logic              out_valid,
  input  logic              out_ready,
  output gbc_pkg::corr_t    corrected_x,
  output gbc_pkg::corr_t    corrected_y,
  output gbc_pkg::corr_t    corrected_z,
  output logic              calibrated
);

  import gbc_pkg::*;

  localparam int AVG_LOG = $clog2(AVERAGE_SAMPLES);
  localparam int SUM_W   = SAMPLE_W + AVG_LOG;
  localparam int PROD_W  = 2 * SUM_W + 1;
  localparam int DIV_SH  = SUM_W + AVG_LOG;
  localparam int CNT_W   = $clog2(WARMUP_SAMPLES + AVERAGE_SAMPLES + 1);

  // ceil(2^DIV_SH / N): exact floor division for every magnitude below 2^SUM_W
  localparam logic [63:0] RECIP_L =
    ((64'd1 << DIV_SH) + 64'(AVERAGE_SAMPLES) - 64'd1) / 64'(AVERAGE_SAMPLES);
  localparam logic [SUM_W:0] RECIP = RECIP_L[SUM_W:0];

  localparam logic [CNT_W-1:0] FIRST_AVG = CNT_W'(WARMUP_SAMPLES + 1);
  localparam logic [CNT_W-1:0] LAST_AVG  = CNT_W'(WARMUP_SAMPLES + AVERAGE_SAMPLES);
  localparam logic [CNT_W-1:0] WARM_END  = CNT_W'(WARMUP_SAMPLES);

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic        [SUM_W-1:0] mag_t;
  typedef logic        [PROD_W-1:0] prod_t;

  // stage valids and enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  logic accept;

  assign en4      = !v4 || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // calibration state: sample counter, done flag, per-axis sums
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             done, done_next;
  sum_t             sum [NUM_AXES];
  sum_t             sum_next [NUM_AXES];
  logic             fin_next;
  sample_vec_t      smp_in;
  logic [CNT_W-1:0] cnt_base, cnt_inc;
  logic             done_base;

  assign smp_in[0] = rate_x;
  assign smp_in[1] = rate_y;
  assign smp_in[2] = rate_z;

  always_comb begin
    cnt_base  = restart ? '0 : cnt;
    done_base = restart ? 1'b0 : done;
    cnt_inc   = cnt_base + CNT_W'(1);
    cnt_next  = cnt_base;
    done_next = done_base;
    fin_next  = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      sum_next[i] = sum[i];
    end
    if (!done_base) begin
      cnt_next = cnt_inc;
      if (cnt_inc > WARM_END) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if (cnt_inc == FIRST_AVG) begin
            sum_next[i] = SUM_W'(smp_in[i]);
          end else begin
            sum_next[i] = sum[i] + SUM_W'(smp_in[i]);
          end
        end
        if (cnt_inc >= LAST_AVG) begin
          fin_next  = 1'b1;
          done_next = 1'b1;
          cnt_next  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        sum[i] <= '0;
      end
    end else if (accept) begin
      cnt  <= cnt_next;
      done <= done_next;
      for (int i = 0; i < NUM_AXES; i++) begin
        sum[i] <= sum_next[i];
      end
    end
  end

  // stage 1 payload
  sample_vec_t s1_smp;
  sum_t        s1_sum [NUM_AXES];
  logic        s1_fin, s1_done;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_smp  <= smp_in;
      s1_fin  <= fin_next;
      s1_done <= done_next;
      for (int i = 0; i < NUM_AXES; i++) begin
        s1_sum[i] <= sum_next[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 2
  // sign and magnitude of each axis sum
  sample_vec_t s2_smp;
  mag_t        s2_mag [NUM_AXES];
  logic        s2_neg [NUM_AXES];
  logic        s2_fin, s2_done;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_smp  <= s1_smp;
      s2_fin  <= s1_fin;
      s2_done <= s1_done;
      for (int i = 0; i < NUM_AXES; i++) begin
        s2_neg[i] <= s1_sum[i][SUM_W-1];
        s2_mag[i] <= s1_sum[i][SUM_W-1] ? mag_t'(-s1_sum[i]) : mag_t'(s1_sum[i]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  // magnitude times reciprocal, quotient sits at bit DIV_SH
  sample_vec_t s3_smp;
  prod_t       s3_prod [NUM_AXES];
  logic        s3_neg [NUM_AXES];
  logic        s3_fin, s3_done;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_smp  <= s2_smp;
      s3_fin  <= s2_fin;
      s3_done <= s2_done;
      for (int i = 0; i < NUM_AXES; i++) begin
        s3_neg[i]  <= s2_neg[i];
        s3_prod[i] <= PROD_W'(s2_mag[i]) * PROD_W'(RECIP);
      end
    end
  end

  // ---------------------------------------------------------------- stage 4
  // bias update on completion, then sample minus bias
  sample_vec_t bias;
  sample_vec_t bias_new;
  sample_vec_t bias_use;
  quot_t       quot [NUM_AXES];
  corr_vec_t   corr_next;
  corr_vec_t   corr;
  logic        cal;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      quot[i]      = s3_prod[i][DIV_SH +: SAMPLE_W];
      bias_new[i]  = s3_neg[i] ? sample_t'(-quot[i]) : sample_t'(quot[i]);
      bias_use[i]  = s3_fin ? bias_new[i] : bias[i];
      corr_next[i] = CORR_W'(s3_smp[i]) - CORR_W'(bias_use[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        bias[i] <= '0;
      end
    end else if (en4 && v3 && s3_fin) begin
      bias <= bias_new;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      corr <= corr_next;
      cal  <= s3_done;
    end
  end

  assign out_valid   = v4;
  assign corrected_x = corr[0];
  assign corrected_y = corr[1];
  assign corrected_z = corr[2];
  assign calibrated  = cal;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking bench for gyro_bias_calibrator: random and directed rate samples,
// an in-bench bias calibration predictor and a field-by-field result check.
// Depends on gbc_pkg and gyro_bias_calibrator from rtl.
`timescale 1ns / 1ps

module tb_top;
  import gbc_pkg::*;

  localparam int WARMUP_SAMPLES  = 800;
  localparam int AVERAGE_SAMPLES = 800;
  localparam int DRAIN_CYCLES    = 20;
  localparam int MAX_REPORTS     = 20;

  typedef struct {
    logic    restart;
    sample_t rate_x;
    sample_t rate_y;
    sample_t rate_z;
  } rate_req_t;

  typedef struct {
    corr_t corr_x;
    corr_t corr_y;
    corr_t corr_z;
    logic  cal;
  } corr_result_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_ready;
  logic    restart = 1'b0;
  sample_t rate_x = '0;
  sample_t rate_y = '0;
  sample_t rate_z = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  corr_t   corrected_x;
  corr_t   corrected_y;
  corr_t   corrected_z;
  logic    calibrated;

  gyro_bias_calibrator #(
    .WARMUP_SAMPLES (WARMUP_SAMPLES),
    .AVERAGE_SAMPLES(AVERAGE_SAMPLES)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .rate_x     (rate_x),
    .rate_y     (rate_y),
    .rate_z     (rate_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .corrected_x(corrected_x),
    .corrected_y(corrected_y),
    .corrected_z(corrected_z),
    .calibrated (calibrated)
  );

  // Request stream and outstanding corrected samples
  rate_req_t    pending_rates[$];
  corr_result_t expected_corr[$];
  rate_req_t    cur_req;

  // Predictor state
  int unsigned warm_count;
  bit          bias_ready;
  longint      axis_acc[3];
  int          axis_bias[3];

  int reqs_sent;
  int results_seen;
  int mismatches;
  int restarts_seen;
  int cal_completions;
  int send_gap;
  int stall_left;
  int drv_quiet;
  int mon_quiet;

  // Bias calibration predictor; advances its own state by one sample
  function automatic corr_result_t predict_correction(rate_req_t r);
    int s[3];
    corr_result_t res;
    s[0] = r.rate_x;
    s[1] = r.rate_y;
    s[2] = r.rate_z;
    if (r.restart) begin
      warm_count = 0;
      bias_ready = 1'b0;
      restarts_seen++;
    end
    if (!bias_ready) begin
      warm_count++;
      if (warm_count > WARMUP_SAMPLES) begin
        for (int i = 0; i < 3; i++) begin
          if (warm_count == WARMUP_SAMPLES + 1) axis_acc[i] = s[i];
          else axis_acc[i] += s[i];
        end
        if (warm_count >= WARMUP_SAMPLES + AVERAGE_SAMPLES) begin
          // signed division truncates toward zero
          for (int i = 0; i < 3; i++)
            axis_bias[i] = int'(axis_acc[i] / longint'(AVERAGE_SAMPLES));
          bias_ready = 1'b1;
          warm_count = 0;
          cal_completions++;
        end
      end
    end
    res.corr_x = corr_t'(s[0] - axis_bias[0]);
    res.corr_y = corr_t'(s[1] - axis_bias[1]);
    res.corr_z = corr_t'(s[2] - axis_bias[2]);
    res.cal    = bias_ready;
    return res;
  endfunction

  // Idle length: mostly short, a few long, with quiet stretches of no idling
  function automatic int idle_len(ref int quiet_left);
    int pick;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 149) == 0) begin
      quiet_left = $urandom_range(40, 160);
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int near_rate(int center, int spread);
    int v;
    v = center + $urandom_range(0, 2 * spread) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic int pick_center();
    case ($urandom_range(0, 2))
      0: return -32768;
      1: return 32767;
      default: return near_rate(0, 32768);
    endcase
  endfunction

  task automatic add_req(bit rs, int x, int y, int z);
    rate_req_t r;
    r.restart = rs;
    r.rate_x  = sample_t'(x);
    r.rate_y  = sample_t'(y);
    r.rate_z  = sample_t'(z);
    pending_rates.push_back(r);
  endtask

  // Full-range samples; restart set on the first one if asked
  task automatic add_noise(int n, bit first_restart);
    for (int i = 0; i < n; i++)
      add_req(first_restart && i == 0, $urandom, $urandom, $urandom);
  endtask

  // Samples clustered around a per-axis zero-rate offset
  task automatic add_cluster(int n, int cx, int cy, int cz, int spread);
    for (int i = 0; i < n; i++)
      add_req(1'b0, near_rate(cx, spread), near_rate(cy, spread), near_rate(cz, spread));
  endtask

  task automatic wait_idle();
    while (pending_rates.size() != 0 || in_valid || expected_corr.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endtask

  // Clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Request driver
  always @(posedge clk) begin
    rate_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_corr.push_back(predict_correction(cur_req));
        reqs_sent++;
      end
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_rates.size() != 0) begin
        req = pending_rates.pop_front();
        cur_req  <= req;
        restart  <= req.restart;
        rate_x   <= req.rate_x;
        rate_y   <= req.rate_y;
        rate_z   <= req.rate_z;
        in_valid <= 1'b1;
        send_gap <= idle_len(drv_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    corr_result_t exp_r;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_corr.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual %0d %0d %0d cal=%0b",
                     $time, corrected_x, corrected_y, corrected_z, calibrated);
        end else begin
          exp_r = expected_corr.pop_front();
          check_field("corrected_x", exp_r.corr_x, corrected_x);
          check_field("corrected_y", exp_r.corr_y, corrected_y);
          check_field("corrected_z", exp_r.corr_z, corrected_z);
          check_field("calibrated", exp_r.cal, calibrated);
        end
      end
      if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready  <= 1'b1;
        stall_left <= idle_len(mon_quiet);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int cx;
    int cy;
    int cz;
    int spread;
    warm_count = 0;
    bias_ready = 1'b0;
    for (int i = 0; i < 3; i++) begin
      axis_acc[i]  = 0;
      axis_bias[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes and bit patterns during warmup, restarts mid-warmup
    add_req(1'b1, -32768, 32767, 0);
    add_req(1'b0, 32767, 32767, 32767);
    add_req(1'b0, -32768, -32768, -32768);
    add_req(1'b0, 0, 0, 0);
    add_req(1'b0, -1, 1, -1);
    add_req(1'b0, 16'h5555, 16'haaaa, 16'h5555);
    add_req(1'b0, 16'haaaa, 16'h5555, 16'haaaa);
    add_req(1'b1, 1, -1, 1);
    add_req(1'b1, 32767, -32768, -1);
    add_req(1'b0, -32767, 32766, 16'h8001);
    add_req(1'b0, 12345, -12345, 256);
    add_req(1'b1, 0, 0, 0);
    wait_idle();

    // Full calibration; offsets often pinned at the rails for extreme outputs
    cx = pick_center();
    cy = pick_center();
    cz = -cx;
    spread = $urandom_range(0, 1) ? 0 : $urandom_range(1, 400);
    add_noise(WARMUP_SAMPLES, 1'b1);
    add_cluster(AVERAGE_SAMPLES, cx, cy, cz, spread);
    add_req(1'b0, 32767, -32768, 32767);
    add_req(1'b0, -32768, 32767, -32768);
    add_noise(80, 1'b0);
    wait_idle();

    // Restart while calibrated: old bias must stay in use
    add_noise(150, 1'b1);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_corr.size() != 0) begin
      mismatches++;
      $display("%0t: %0d corrected samples never arrived", $time, expected_corr.size());
    end
    $display("Sent %0d rate samples, checked %0d corrected samples.", reqs_sent, results_seen);
    $display("Restarts: %0d, completed calibrations: %0d, mismatches: %0d.",
             restarts_seen, cal_completions, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout with %0d samples pending and %0d results outstanding.",
             pending_rates.size(), expected_corr.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
